// ===== sv/cnw_pkg.sv =====
// ----------------------------------------------------------------------------
// cnw_pkg
// Shared types and constants of the character LCD nibble writer: payload
// structs, configuration struct, item kinds, register indexes, characters.
// ----------------------------------------------------------------------------
package cnw_pkg;

	// input word
	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         row;
		logic [4:0]         column;
		logic [7:0]         byte_value;
		logic signed [31:0] number;
		logic [3:0]         pad_width;
	} cnw_in_t;

	// output word
	typedef struct packed {
		logic [7:0] shift_word;
		logic [7:0] hold_us;
		logic       last;
	} cnw_out_t;

	// one display byte queued between front and back
	typedef struct packed {
		logic [7:0] value;
		logic       is_data;
		logic       last;
	} cnw_job_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [2:0] enable_bit;
		logic [2:0] select_bit;
		logic [7:0] command_hold_us;
		logic [7:0] data_hold_us;
	} cnw_cfg_t;

	typedef enum logic [1:0] {
		KIND_COMMAND  = 2'd0,
		KIND_POSITION = 2'd1,
		KIND_INTEGER  = 2'd2,
		KIND_TEXT     = 2'd3
	} cnw_kind_t;

	typedef enum logic [1:0] {
		REG_ENABLE_BIT      = 2'd0,
		REG_SELECT_BIT      = 2'd1,
		REG_COMMAND_HOLD_US = 2'd2,
		REG_DATA_HOLD_US    = 2'd3
	} cnw_reg_t;

	localparam logic [2:0] ENABLE_BIT_RESET   = 3'd5;
	localparam logic [2:0] SELECT_BIT_RESET   = 3'd4;
	localparam logic [7:0] COMMAND_HOLD_RESET = 8'd37;
	localparam logic [7:0] DATA_HOLD_RESET    = 8'd50;

	localparam logic [7:0] SET_ADDR   = 8'h80;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;
	localparam logic [3:0] MAX_PRINT  = 4'd15;

	// display address of the first column of a row
	function automatic logic [7:0] row_start(input logic [1:0] row);
		logic [7:0] addr;
		unique case (row)
			2'd0: addr = 8'h00;
			2'd1: addr = 8'h40;
			2'd2: addr = 8'h14;
			default: addr = 8'h54;
		endcase
		return addr;
	endfunction

endpackage

// ===== sv/cnw_fifo.sv =====
// ----------------------------------------------------------------------------
// cnw_fifo
// Small show-ahead queue of display bytes between the front and back ends.
// ----------------------------------------------------------------------------
module cnw_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cnw_pkg::cnw_job_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output cnw_pkg::cnw_job_t head_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cnw_pkg::cnw_job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/cnw_front.sv =====
// ----------------------------------------------------------------------------
// cnw_front
// Accepts input words, classifies them by kind and queues display bytes.
// Integers are split into decimal digits one digit a cycle.
// ----------------------------------------------------------------------------
module cnw_front #(
	parameter int COLUMNS   = 20,
	parameter int MAX_CHARS = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  cnw_pkg::cnw_in_t  item,
	output logic              push,
	output cnw_pkg::cnw_job_t push_data,
	input  logic              full
);

	localparam int LW = $clog2(MAX_CHARS + 1);
	localparam int IW = $clog2(MAX_CHARS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t        state_q;
	logic [4:0]    text_column_q;
	logic [30:0]   mag_q;
	logic          neg_q;
	logic [LW-1:0] cnt_q;
	logic [3:0]    printed_q;
	logic [3:0]    pad_q;
	logic [7:0]    digit_q [MAX_CHARS];

	logic          accept;
	logic [7:0]    pos_byte;
	logic [31:0]   mag_abs;
	logic [30:0]   mag_sat;
	logic [62:0]   prod;
	logic [27:0]   quot;
	logic [30:0]   quot10;
	logic [3:0]    rem;
	logic          room;
	logic          have_digit;
	logic [LW-1:0] next_cnt;
	logic [3:0]    next_printed;
	logic          more;
	logic          text_fits;

	assign item_ready = (state_q == ST_IDLE) && !full;
	assign accept     = item_valid && item_ready;
	assign pos_byte   = cnw_pkg::SET_ADDR + cnw_pkg::row_start(item.row) + {3'b000, item.column};
	assign text_fits  = 32'(text_column_q) < COLUMNS;

	// magnitude, most negative value saturated
	assign mag_abs = item.number[31] ? (~item.number + 32'd1) : item.number;
	assign mag_sat = mag_abs[31] ? 31'h7FFF_FFFF : mag_abs[30:0];

	// divide by ten through the reciprocal
	assign prod   = 63'(mag_q) * 63'(32'hCCCC_CCCD);
	assign quot   = prod[62:35];
	assign quot10 = 31'({quot, 3'b000}) + 31'({quot, 1'b0});
	assign rem    = 4'(mag_q - quot10);
	assign room   = 32'(cnt_q) < MAX_CHARS;

	// next printed character
	assign have_digit   = (cnt_q != '0) && (printed_q != cnw_pkg::MAX_PRINT);
	assign next_cnt     = have_digit ? cnt_q - 1'b1 : cnt_q;
	assign next_printed = printed_q + 1'b1;
	assign more         = ((next_cnt != '0) && (next_printed != cnw_pkg::MAX_PRINT))
		|| (next_printed < pad_q);

	// queue write
	always_comb begin
		push      = 1'b0;
		push_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.kind)
						cnw_pkg::KIND_COMMAND: begin
							push      = 1'b1;
							push_data = '{value: item.byte_value, is_data: 1'b0, last: 1'b1};
						end
						cnw_pkg::KIND_POSITION: begin
							push      = 1'b1;
							push_data = '{value: pos_byte, is_data: 1'b0, last: 1'b1};
						end
						cnw_pkg::KIND_INTEGER: begin
							push      = 1'b1;
							push_data = '{value: pos_byte, is_data: 1'b0, last: 1'b0};
						end
						default: begin
							push      = text_fits;
							push_data = '{value: item.byte_value, is_data: 1'b1, last: 1'b1};
						end
					endcase
				end
			end
			ST_EMIT: begin
				push      = !full;
				push_data = '{
					value:   have_digit ? digit_q[IW'(cnt_q - 1'b1)] : cnw_pkg::CHAR_SPACE,
					is_data: 1'b1,
					last:    !more
				};
			end
			default: begin
				push      = 1'b0;
				push_data = '0;
			end
		endcase
	end

	// digit buffer
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && room) begin
			digit_q[IW'(cnt_q)] <= cnw_pkg::CHAR_ZERO + {4'h0, rem};
		end else if (state_q == ST_SIGN && room) begin
			digit_q[IW'(cnt_q)] <= cnw_pkg::CHAR_MINUS;
		end
	end

	// integer working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mag_q     <= mag_sat;
				neg_q     <= item.number[31];
				pad_q     <= item.pad_width;
				cnt_q     <= '0;
				printed_q <= '0;
			end
			ST_DIV: begin
				mag_q <= 31'(quot);
				if (room) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_SIGN: begin
				if (room) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
				if (!full) begin
					cnt_q     <= next_cnt;
					printed_q <= next_printed;
				end
			end
		endcase
	end

	// sequencer and text column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			text_column_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.kind)
							cnw_pkg::KIND_POSITION: text_column_q <= item.column;
							cnw_pkg::KIND_INTEGER:  state_q <= ST_DIV;
							cnw_pkg::KIND_TEXT: begin
								if (text_fits) begin
									text_column_q <= text_column_q + 5'd1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (quot == '0) begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: state_q <= ST_EMIT;
				default: begin
					if (!full && !more) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== sv/cnw_back.sv =====
// ----------------------------------------------------------------------------
// cnw_back
// Expands each queued display byte into four shift words (high nibble with
// and without E, low nibble with and without E) behind an output register.
// ----------------------------------------------------------------------------
module cnw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cnw_pkg::cnw_cfg_t cfg,
	input  logic              head_valid,
	input  cnw_pkg::cnw_job_t head_data,
	output logic              pop,
	output logic              word_valid,
	input  logic              word_ready,
	output cnw_pkg::cnw_out_t word
);

	logic [1:0]        phase_q;
	logic              word_valid_q;
	cnw_pkg::cnw_out_t word_q;

	logic              load;
	logic [7:0]        e_mask;
	logic [7:0]        rs_mask;
	logic [3:0]        nibble;
	cnw_pkg::cnw_out_t next_word;

	assign word_valid = word_valid_q;
	assign word       = word_q;
	assign load       = !word_valid_q || word_ready;
	assign pop        = load && head_valid && (phase_q == 2'd3);

	// word for the current phase
	assign e_mask  = 8'd1 << cfg.enable_bit;
	assign rs_mask = head_data.is_data ? (8'd1 << cfg.select_bit) : 8'd0;
	assign nibble  = phase_q[1] ? (head_data.value[3:0] & cnw_pkg::NIBBLE_MASK)
		: head_data.value[7:4];
	always_comb begin
		next_word.shift_word = {4'h0, nibble} | rs_mask | (phase_q[0] ? 8'd0 : e_mask);
		next_word.hold_us    = phase_q[0]
			? (head_data.is_data ? cfg.data_hold_us : cfg.command_hold_us) : 8'd0;
		next_word.last       = head_data.last && (phase_q == 2'd3);
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			word_q <= next_word;
		end
	end

	// output valid and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
			phase_q      <= '0;
		end else if (load) begin
			word_valid_q <= head_valid;
			if (head_valid) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

endmodule

// ===== sv/char_lcd_nibble_writer_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit
// Character LCD writer for a 4-bit bus behind an external shift register.
//
//   channel   signals                        direction   content
//   item      item_valid/item_ready/item     in          cnw_in_t
//   word      word_valid/word_ready/word     out         cnw_out_t
//   config    cfg_we/cfg_index/cfg_data      in          register writes
//
// Every display byte becomes four words from the back end, one word a
// cycle while word_ready is high, so an integer gives up to 64 words. The
// divider forms the decimal digits and then the sign while the back end
// sends the position words.
// The front takes a new item only when idle with room in the queue.
// Reset restores the register defaults and clears the text column.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_unit #(
	parameter int COLUMNS     = 20,
	parameter int MAX_CHARS   = 11,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  cnw_pkg::cnw_in_t  item,
	output logic              word_valid,
	input  logic              word_ready,
	output cnw_pkg::cnw_out_t word,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	cnw_pkg::cnw_cfg_t cfg_q;
	logic              push;
	cnw_pkg::cnw_job_t push_data;
	logic              full;
	logic              pop;
	logic              head_valid;
	cnw_pkg::cnw_job_t head_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_bit      <= cnw_pkg::ENABLE_BIT_RESET;
			cfg_q.select_bit      <= cnw_pkg::SELECT_BIT_RESET;
			cfg_q.command_hold_us <= cnw_pkg::COMMAND_HOLD_RESET;
			cfg_q.data_hold_us    <= cnw_pkg::DATA_HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cnw_pkg::REG_ENABLE_BIT:      cfg_q.enable_bit      <= cfg_data[2:0];
				cnw_pkg::REG_SELECT_BIT:      cfg_q.select_bit      <= cfg_data[2:0];
				cnw_pkg::REG_COMMAND_HOLD_US: cfg_q.command_hold_us <= cfg_data;
				default:                      cfg_q.data_hold_us    <= cfg_data;
			endcase
		end
	end

	// front end: classify and split integers
	cnw_front #(
		.COLUMNS   (COLUMNS),
		.MAX_CHARS (MAX_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	// byte queue
	cnw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// back end: nibble words
	cnw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word)
	);

endmodule
